>>> rtl/core/gfa_pkg.sv
`default_nettype none
package gfa_pkg;
    localparam logic [63:0] FieldP   = 64'hFFFF_FFFF_0000_0001;
    localparam logic [63:0] Eps32    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] RootGen  = 64'd7;
    localparam logic [63:0] MaxLog2  = 64'd32;

    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_MUL  = 4'd2,
        FN_NEG  = 4'd3,
        FN_POW  = 4'd4,
        FN_INV  = 4'd5,
        FN_DIV  = 4'd6,
        FN_MONT = 4'd7,
        FN_ROOT = 4'd8
    } t_func;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StInvZero = 2'd1;
    localparam logic [1:0] StRootBig = 2'd2;

    typedef struct packed {
        logic [3:0]  func;
        logic [63:0] opnd_a;
        logic [63:0] opnd_b;
    } t_req;

    typedef struct packed {
        logic [63:0] result;
        logic [1:0]  status;
    } t_rsp;

    // multiplier handshake
    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] y;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

    function automatic logic [63:0] canon(input logic [63:0] x);
        return (x >= FieldP) ? x - FieldP : x;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/gfa_if.sv
`default_nettype none
interface gfa_req_if;
    import gfa_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface gfa_rsp_if;
    import gfa_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/goldilocks_field_alu.sv
// add, sub, neg, from_montgomery: result registered on accept, then marked valid; mul: one multiply
// pow, inv, root: 64 exponent steps of one or two multiplies through the shared
// four-step 32x32 multiplier; div adds one multiply
// one item at a time; next item accepted the cycle after the result transfer
// reset: synchronous active low, clears sequencer and valid flags
`default_nettype none
module goldilocks_field_alu (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gfa_req_if.sink   in_if,
    gfa_rsp_if.source out_if
);
    import gfa_pkg::*;

    t_mul_req w_mreq;
    t_mul_rsp w_mrsp;

    gfa_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_if  (in_if),
        .out_if (out_if),
        .o_mreq (w_mreq),
        .i_mrsp (w_mrsp)
    );

    gfa_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_rsp  (w_mrsp)
    );
endmodule
`default_nettype wire

>>> rtl/core/gfa_mul.sv
`default_nettype none
module gfa_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gfa_pkg::t_mul_req i_req,
    output gfa_pkg::t_mul_rsp      o_rsp
);
    import gfa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_P0, S_P1, S_P2, S_P3, S_RED} t_state;

    t_state      r_state;
    logic [63:0] r_x, r_y;
    logic [63:0] r_ll, r_lh, r_hl, r_hh;
    logic [63:0] r_p;
    logic        r_done;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_red;

    // one 32x32 partial product per cycle
    always_comb begin
        case (r_state)
            S_P0:    begin w_ma = r_x[31:0];  w_mb = r_y[31:0];  end
            S_P1:    begin w_ma = r_x[31:0];  w_mb = r_y[63:32]; end
            S_P2:    begin w_ma = r_x[63:32]; w_mb = r_y[31:0];  end
            default: begin w_ma = r_x[63:32]; w_mb = r_y[63:32]; end
        endcase
        w_prod = {32'd0, w_ma} * {32'd0, w_mb};
    end

    // reduction with 2^64 = 2^32-1 and 2^96 = -1
    always_comb begin
        logic [63:0] mid, lo, hi, top, lowhi, t0, t1, t2;
        mid   = {32'd0, r_ll[63:32]} + {32'd0, r_lh[31:0]} + {32'd0, r_hl[31:0]};
        lo    = {mid[31:0], r_ll[31:0]};
        hi    = r_hh + {32'd0, r_lh[63:32]} + {32'd0, r_hl[63:32]} + {32'd0, mid[63:32]};
        top   = {32'd0, hi[63:32]};
        lowhi = {32'd0, hi[31:0]};
        t0    = lo - top;
        if (lo < top) t0 = t0 - Eps32;
        t1    = (lowhi << 32) - lowhi;
        t2    = t0 + t1;
        if (t2 < t0) t2 = t2 + Eps32;
        w_red = canon(t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_req.start) begin
                    r_x <= i_req.x;
                    r_y <= i_req.y;
                    r_state <= S_P0;
                end
                S_P0: begin r_ll <= w_prod; r_state <= S_P1; end
                S_P1: begin r_lh <= w_prod; r_state <= S_P2; end
                S_P2: begin r_hl <= w_prod; r_state <= S_P3; end
                S_P3: begin r_hh <= w_prod; r_state <= S_RED; end
                S_RED: begin
                    r_p <= w_red;
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;
endmodule
`default_nettype wire

>>> rtl/core/gfa_seq.sv
`default_nettype none
module gfa_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gfa_req_if.sink                in_if,
    gfa_rsp_if.source              out_if,
    output gfa_pkg::t_mul_req      o_mreq,
    input  wire gfa_pkg::t_mul_rsp i_mrsp
);
    import gfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SQM, S_WSQ, S_WAC, S_DIVM, S_WDIV, S_MULW, S_OUT
    } t_state;

    t_state      r_state;
    logic [3:0]  r_func;
    logic [63:0] r_a;
    logic [63:0] r_base, r_acc, r_exp;
    logic [6:0]  r_cnt;
    logic [63:0] r_res;
    logic [1:0]  r_st;
    logic        r_mstart;
    logic [63:0] r_mx, r_my;
    logic        r_vld;

    logic [63:0] w_a, w_b, w_sum, w_add, w_sub, w_neg, w_mont;
    logic [63:0] w_root_exp;
    logic        w_carry;

    // operand reduction, combinational add/sub/neg/from_montgomery, root exponent
    always_comb begin
        logic [63:0] sh, ta, tb;
        w_a = canon(in_if.data.opnd_a);
        w_b = canon(in_if.data.opnd_b);
        {w_carry, w_sum} = {1'b0, w_a} + {1'b0, w_b};
        w_add = (w_carry || w_sum >= FieldP) ? w_sum - FieldP : w_sum;
        w_sub = (w_a < w_b) ? w_a - w_b + FieldP : w_a - w_b;
        w_neg = (w_a == 64'd0) ? 64'd0 : FieldP - w_a;
        sh = in_if.data.opnd_a << 32;
        ta = in_if.data.opnd_a + sh;
        tb = ta - (ta >> 32);
        if (ta < in_if.data.opnd_a) tb = tb - 64'd1;
        w_mont = 64'd0 - tb;
        if (tb != 64'd0) w_mont = w_mont - Eps32;
        w_root_exp = (FieldP - 64'd1) >> in_if.data.opnd_b[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (r_vld && out_if.ready) r_vld <= 1'b0;
            case (r_state)
                // accept and dispatch
                S_IDLE: if (in_if.valid && !r_vld) begin
                    r_func <= in_if.data.func;
                    r_a    <= w_a;
                    r_st   <= StOk;
                    r_res  <= 64'd0;
                    r_acc  <= 64'd1;
                    r_cnt  <= 7'd0;
                    r_state <= S_OUT;
                    case (in_if.data.func)
                        FN_ADD:  r_res <= w_add;
                        FN_SUB:  r_res <= w_sub;
                        FN_NEG:  r_res <= w_neg;
                        FN_MONT: r_res <= w_mont;
                        FN_MUL: begin
                            r_mx <= w_a; r_my <= w_b; r_mstart <= 1'b1;
                            r_state <= S_MULW;
                        end
                        FN_POW: begin
                            r_base <= w_a; r_exp <= in_if.data.opnd_b;
                            r_state <= S_SQM;
                        end
                        FN_INV: begin
                            if (w_a == 64'd0) r_st <= StInvZero;
                            else begin
                                r_base <= w_a; r_exp <= FieldP - 64'd2;
                                r_state <= S_SQM;
                            end
                        end
                        FN_DIV: begin
                            if (w_b == 64'd0) r_st <= StInvZero;
                            else begin
                                r_base <= w_b; r_exp <= FieldP - 64'd2;
                                r_state <= S_SQM;
                            end
                        end
                        FN_ROOT: begin
                            if (in_if.data.opnd_b > MaxLog2) r_st <= StRootBig;
                            else begin
                                r_base <= RootGen; r_exp <= w_root_exp;
                                r_state <= S_SQM;
                            end
                        end
                        default: ;
                    endcase
                end
                // one exponent bit: optional multiply then square; after 64 bits, result or div multiply
                S_SQM: begin
                    if (r_cnt[6]) begin
                        if (r_func == FN_DIV) begin
                            r_mx <= r_a; r_my <= r_acc; r_mstart <= 1'b1;
                            r_state <= S_WDIV;
                        end else begin
                            r_res <= r_acc;
                            r_state <= S_OUT;
                        end
                    end else if (r_exp[0]) begin
                        r_mx <= r_acc; r_my <= r_base; r_mstart <= 1'b1;
                        r_state <= S_WAC;
                    end else begin
                        r_mx <= r_base; r_my <= r_base; r_mstart <= 1'b1;
                        r_state <= S_WSQ;
                    end
                end
                S_WAC: if (i_mrsp.done) begin
                    r_acc <= i_mrsp.p;
                    r_mx <= r_base; r_my <= r_base; r_mstart <= 1'b1;
                    r_state <= S_WSQ;
                end
                S_WSQ: if (i_mrsp.done) begin
                    r_base <= i_mrsp.p;
                    r_exp  <= r_exp >> 1;
                    r_cnt  <= r_cnt + 7'd1;
                    r_state <= S_SQM;
                end
                S_WDIV, S_MULW: if (i_mrsp.done) begin
                    r_res <= i_mrsp.p;
                    r_state <= S_OUT;
                end
                // result register marked valid
                S_OUT: begin
                    r_vld <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign in_if.ready        = (r_state == S_IDLE) && !r_vld;
    assign out_if.valid       = r_vld;
    assign out_if.data.result = r_res;
    assign out_if.data.status = r_st;
    assign o_mreq.start       = r_mstart;
    assign o_mreq.x           = r_mx;
    assign o_mreq.y           = r_my;
endmodule
`default_nettype wire

>>> rtl/core/gfa_checker.sv
`default_nettype none
module gfa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_result,
    input wire logic [1:0]  out_status
);
    // no new transfer while a result waits
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    // busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
    // status never out of range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status != 2'd3) else $error("bad status");
    // error result is zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_status != 2'd0) |-> out_result == 64'd0)
        else $error("nonzero result on error");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_result)))
        else $error("result dropped");
endmodule

bind goldilocks_field_alu gfa_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_result(out_if.data.result),
    .out_status(out_if.data.status)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import gfa_pkg::*;

    localparam int unsigned CycleLimit = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gfa_req_if req_bus ();
    gfa_rsp_if rsp_bus ();

    goldilocks_field_alu u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_if  (req_bus.sink),
        .out_if (rsp_bus.source)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // field arithmetic predictor
    function automatic logic [63:0] fp_reduce(input logic [63:0] x);
        return (x >= FieldP) ? x - FieldP : x;
    endfunction

    function automatic logic [63:0] fp_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FieldP}) s = s - {1'b0, FieldP};
        return s[63:0];
    endfunction

    function automatic logic [63:0] fp_sub(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a - b + FieldP : a - b;
    endfunction

    function automatic logic [63:0] fp_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, FieldP});
    endfunction

    function automatic logic [63:0] fp_pow(input logic [63:0] base, input logic [63:0] e);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < 64; i++) begin
            if (e[i]) acc = fp_mul(acc, base);
            base = fp_mul(base, base);
        end
        return acc;
    endfunction

    function automatic t_rsp fp_compute(input t_req r);
        t_rsp o;
        logic [63:0] a, b;
        logic [127:0] t;
        a = fp_reduce(r.opnd_a);
        b = fp_reduce(r.opnd_b);
        o.result = '0;
        o.status = StOk;
        case (r.func)
            FN_ADD:  o.result = fp_add(a, b);
            FN_SUB:  o.result = fp_sub(a, b);
            FN_MUL:  o.result = fp_mul(a, b);
            FN_NEG:  o.result = (a == 0) ? 64'd0 : FieldP - a;
            FN_POW:  o.result = fp_pow(a, r.opnd_b);
            FN_INV:
                if (a == 0) o.status = StInvZero;
                else o.result = fp_pow(a, FieldP - 64'd2);
            FN_DIV:
                if (b == 0) o.status = StInvZero;
                else o.result = fp_mul(a, fp_pow(b, FieldP - 64'd2));
            FN_MONT: begin
                // raw word times 2^-64: 2^64 mod p is 2^32 - 1
                t = {64'd0, r.opnd_a} * {64'd0, fp_pow(64'hFFFF_FFFF, FieldP - 64'd2)};
                o.result = 64'(t % {64'd0, FieldP});
            end
            FN_ROOT:
                if (r.opnd_b > MaxLog2) o.status = StRootBig;
                else o.result = fp_pow(RootGen, (FieldP - 64'd1) >> r.opnd_b[5:0]);
            default: ;
        endcase
        return o;
    endfunction

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned rsp_count = 0;
    bit quiet_phase = 1'b0;
    bit hold_sender = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_bus.ready) begin
            if (req_bus.valid) expected_rsps.push_back(fp_compute(req_bus.data));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_bus.valid <= 1'b0;
            end else if (!hold_sender && pending_reqs.size() > 0
                         && !(!quiet_phase && $urandom_range(0, 5) == 0)) begin
                req_bus.data <= pending_reqs.pop_front();
                req_bus.valid <= 1'b1;
            end else begin
                req_bus.valid <= 1'b0;
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 3);
            end
        end
    end

    // response monitor and ready control
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                rsp_count <= rsp_count + 1;
                if (expected_rsps.size() == 0) begin
                    $error("response transfer with nothing expected: result %h", rsp_bus.data.result);
                    error_count <= error_count + 1;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp_bus.data.result !== exp_rsp.result) begin
                        $error("result expected %h actual %h", exp_rsp.result, rsp_bus.data.result);
                        error_count <= error_count + 1;
                    end
                    if (rsp_bus.data.status !== exp_rsp.status) begin
                        $error("status expected %0d actual %0d", exp_rsp.status, rsp_bus.data.status);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                rsp_bus.ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                recv_gap <= $urandom_range(0, 2);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("goldilocks_field_alu test failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 3));
            1: v = FieldP - 64'($urandom_range(0, 3));
            2: v = FieldP + 64'($urandom_range(0, 3));
            3: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_req(input t_func f, input logic [63:0] a, input logic [63:0] b);
        t_req r;
        r.func = f;
        r.opnd_a = a;
        r.opnd_b = b;
        pending_reqs.push_back(r);
    endtask

    initial begin
        t_req r;
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        rsp_bus.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, error cases
        queue_req(FN_ADD, FieldP - 64'd1, FieldP - 64'd1);
        queue_req(FN_ADD, 64'hFFFF_FFFF_FFFF_FFFF, FieldP);
        queue_req(FN_SUB, 64'd0, FieldP - 64'd1);
        queue_req(FN_MUL, FieldP - 64'd1, FieldP - 64'd1);
        queue_req(FN_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(FN_NEG, 64'd0, 64'd0);
        queue_req(FN_NEG, FieldP, 64'd5);
        queue_req(FN_POW, 64'd0, 64'd0);
        queue_req(FN_POW, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(FN_INV, 64'd0, 64'd0);
        queue_req(FN_INV, FieldP, 64'd0);
        queue_req(FN_INV, 64'd2, 64'd0);
        queue_req(FN_DIV, 64'd5, 64'd0);
        queue_req(FN_DIV, 64'd5, FieldP);
        queue_req(FN_DIV, FieldP - 64'd1, 64'd7);
        queue_req(FN_MONT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        queue_req(FN_MONT, 64'd0, 64'd0);
        queue_req(FN_ROOT, 64'd0, 64'd0);
        queue_req(FN_ROOT, 64'd0, 64'd32);
        queue_req(FN_ROOT, 64'd0, 64'd33);
        queue_req(FN_ROOT, 64'd0, 64'h8000_0000_0000_0000);
        r.func = 4'd9;  r.opnd_a = '1; r.opnd_b = '1; pending_reqs.push_back(r);
        r.func = 4'd15; pending_reqs.push_back(r);

        // sender holds off until the block has drained
        wait (pending_reqs.size() == 0 && !req_bus.valid);
        hold_sender = 1'b1;
        wait (expected_rsps.size() == 0);
        @(posedge i_clk);
        hold_sender = 1'b0;

        // random part, last stretch without idling
        for (int i = 0; i < 800; i++) begin
            r.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
            r.opnd_a = rand64();
            r.opnd_b = rand64();
            if (r.func == FN_ROOT && $urandom_range(0, 3) != 0)
                r.opnd_b = 64'($urandom_range(0, 34));
            pending_reqs.push_back(r);
            if (i == 700) begin
                wait (pending_reqs.size() == 0);
                quiet_phase = 1'b1;
            end
        end

        wait (pending_reqs.size() == 0 && !req_bus.valid && expected_rsps.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("covered %0d responses over all nine operations, unused codes,", rsp_count);
        $display("non-canonical operands, zero inverses and oversized root orders");
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("goldilocks_field_alu test passed");
        end else begin
            $display("goldilocks_field_alu test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> goldilocks_field_alu.f
rtl/core/gfa_pkg.sv
rtl/core/gfa_if.sv
rtl/core/gfa_mul.sv
rtl/core/gfa_seq.sv
rtl/core/goldilocks_field_alu.sv
rtl/core/gfa_checker.sv
tb/tb.sv
